FILE: hdl/b64_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and character mapping functions for the Base64
// stream codec.
// ----------------------------------------------------------------------------
package b64_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_empty;
      logic       out_last;
   } rsp_type;

   // One completed group, handed from the front end to the output sequencer.
   typedef struct packed {
      logic [23:0] group_val;
      logic        mode;
      logic [2:0]  nchars;
      logic [2:0]  nres;
      logic        last;
      logic        empty;
   } job_type;

   function automatic logic [5:0] b64_char_value(input logic [7:0] c);
      logic [5:0] v;
      v = 6'd0;
      if (c inside {[8'h41:8'h5A]}) begin
         v = 6'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7A]}) begin
         v = 6'(c - 8'h61 + 8'd26);
      end else if (c inside {[8'h30:8'h39]}) begin
         v = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         v = 6'd62;
      end else if (c == 8'h2F) begin
         v = 6'd63;
      end
      return v;
   endfunction

   function automatic logic [7:0] b64_enc_char(input logic [5:0] s);
      logic [7:0] c;
      logic [7:0] s8;
      s8 = {2'b00, s};
      if (s < 6'd26) begin
         c = 8'h41 + s8;
      end else if (s < 6'd52) begin
         c = 8'h61 + s8 - 8'd26;
      end else if (s < 6'd62) begin
         c = 8'h30 + s8 - 8'd52;
      end else if (s == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/base64_stream_codec.sv
// Order: a group completed by a transfer goes into the job queue, then its
//   results enter the response register one per cycle while rsp_ready is high.
// Throughput: one input transfer per cycle while the job queue has room,
//   one result per cycle from the output sequencer while rsp_ready is high (4 per encoded group).
// Reset: synchronous, active high; mode returns to encode, group and queue
//   are emptied, no result is valid.
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming Base64 encoder/decoder, front end and output sequencer
// decoupled by a job queue.
// ----------------------------------------------------------------------------
module base64_stream_codec #(
   parameter int QUEUE_DEPTH = b64_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_wr_data,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire b64_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output b64_pkg::rsp_type       rsp_data
);

   logic             q_full;
   logic             q_empty;
   logic             push_valid;
   logic             pop;
   b64_pkg::job_type push_data;
   b64_pkg::job_type head;

   b64_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .q_full      (q_full),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   b64_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (pop),
      .head       (head),
      .empty      (q_empty)
   );

   b64_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

FILE: hdl/b64_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64_front
// Accepts input transfers, holds the mode register and gathers groups;
// pushes each completed group that yields a result or ends the stream into the job queue.
// ----------------------------------------------------------------------------
module b64_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_wr_data,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire b64_pkg::req_type  req_data,
   input  wire logic              q_full,
   output logic                   push_valid,
   output b64_pkg::job_type       push_data
);

   logic        mode_ff;
   logic [17:0] bits_ff, bits_in;
   logic [1:0]  count_ff, count_in;
   logic [1:0]  pads_ff, pads_in;

   logic        accept;
   logic [2:0]  n;
   logic        complete;
   logic [5:0]  v;
   logic        is_pad;
   logic [2:0]  pads_sum;
   logic [1:0]  pads;
   logic [23:0] acc;
   logic [2:0]  nbytes;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      v        = b64_pkg::b64_char_value(req_data.in_byte);
      is_pad   = (req_data.in_byte == b64_pkg::PAD_CHAR);
      pads_sum = {1'b0, pads_ff} + {2'b00, is_pad};
      pads     = (pads_sum > 3'd3) ? 2'd3 : pads_sum[1:0];
      acc      = {bits_ff, v};
      nbytes   = 3'd0;
      bits_in  = bits_ff;
      count_in = count_ff;
      pads_in  = pads_ff;
      push_valid = 1'b0;
      push_data  = '0;
      push_data.mode = mode_ff;
      push_data.last = req_data.in_last;

      if (mode_ff == b64_pkg::MODE_ENCODE) begin
         n        = (count_ff >= 2'd2) ? 3'd3 : {1'b0, count_ff} + 3'd1;
         complete = (n == 3'd3) || req_data.in_last;
         case (n)
            3'd3:    push_data.group_val = {bits_ff[15:0], req_data.in_byte};
            3'd2:    push_data.group_val = {bits_ff[7:0], req_data.in_byte, 8'h00};
            default: push_data.group_val = {req_data.in_byte, 16'h0000};
         endcase
         push_data.nchars = n + 3'd1;
         push_data.nres   = 3'd4;
         if (accept) begin
            if (complete) begin
               push_valid = 1'b1;
               bits_in    = '0;
               count_in   = '0;
               pads_in    = '0;
            end else begin
               bits_in  = {bits_ff[9:0], req_data.in_byte};
               count_in = n[1:0];
            end
         end
      end else begin
         n        = {1'b0, count_ff} + 3'd1;
         complete = (n == 3'd4) || req_data.in_last;
         case (n)
            3'd1:    push_data.group_val = {acc[5:0], 18'h0};
            3'd2:    push_data.group_val = {acc[11:0], 12'h0};
            3'd3:    push_data.group_val = {acc[17:0], 6'h0};
            default: push_data.group_val = acc;
         endcase
         if ((n - 3'd1) > {1'b0, pads}) begin
            nbytes = n - 3'd1 - {1'b0, pads};
         end
         push_data.nchars = 3'd0;
         if (nbytes == 3'd0) begin
            push_data.nres  = 3'd1;
            push_data.empty = 1'b1;
            push_data.group_val = '0;
         end else begin
            push_data.nres = nbytes;
         end
         if (accept) begin
            if (complete) begin
               push_valid = (nbytes != 3'd0) || req_data.in_last;
               bits_in    = '0;
               count_in   = '0;
               pads_in    = '0;
            end else begin
               bits_in  = {bits_ff[11:0], v};
               count_in = n[1:0];
               pads_in  = pads;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= b64_pkg::MODE_ENCODE;
         bits_ff  <= '0;
         count_ff <= '0;
         pads_ff  <= '0;
      end else if (csr_wr_en) begin
         mode_ff  <= csr_wr_data;
         bits_ff  <= '0;
         count_ff <= '0;
         pads_ff  <= '0;
      end else begin
         bits_ff  <= bits_in;
         count_ff <= count_in;
         pads_ff  <= pads_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/b64_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64_queue
// Small job FIFO between the front end and the output sequencer.
// ----------------------------------------------------------------------------
module b64_queue #(
   parameter int DEPTH = b64_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   input  wire b64_pkg::job_type  push_data,
   output logic                   full,
   input  wire logic              pop,
   output b64_pkg::job_type       head,
   output logic                   empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64_pkg::job_type entries_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/b64_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64_back
// Output sequencer: walks the head job one result per cycle into the
// registered response channel, unless that channel is stalled.
// ----------------------------------------------------------------------------
module b64_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire b64_pkg::job_type  head,
   input  wire logic              q_empty,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output b64_pkg::rsp_type       rsp_data
);

   logic [1:0]       idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   b64_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic       load;
   logic       final_res;
   logic [5:0] sextet;
   logic [7:0] dec_byte;

   assign load      = !q_empty && (!rsp_valid_ff || rsp_ready);
   assign final_res = ({1'b0, idx_ff} == (head.nres - 3'd1));
   assign pop       = load && final_res;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      case (idx_ff)
         2'd0: begin
            sextet   = head.group_val[23:18];
            dec_byte = head.group_val[23:16];
         end
         2'd1: begin
            sextet   = head.group_val[17:12];
            dec_byte = head.group_val[15:8];
         end
         2'd2: begin
            sextet   = head.group_val[11:6];
            dec_byte = head.group_val[7:0];
         end
         default: begin
            sextet   = head.group_val[5:0];
            dec_byte = 8'h00;
         end
      endcase

      if (head.mode == b64_pkg::MODE_ENCODE) begin
         rsp_data_in.out_byte = ({1'b0, idx_ff} < head.nchars) ?
                                b64_pkg::b64_enc_char(sextet) : b64_pkg::PAD_CHAR;
      end else begin
         rsp_data_in.out_byte = head.empty ? 8'h00 : dec_byte;
      end
      rsp_data_in.out_empty = head.empty;
      rsp_data_in.out_last  = head.last && final_res;

      rsp_valid_in = rsp_valid_ff;
      if (!rsp_valid_ff || rsp_ready) begin
         rsp_valid_in = !q_empty;
      end

      idx_in = idx_ff;
      if (load) begin
         idx_in = final_res ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/b64_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64_checker
// Port-level checks for the Base64 stream codec, bound to the top level.
// ----------------------------------------------------------------------------
module b64_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire b64_pkg::req_type  req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire b64_pkg::rsp_type  rsp_data
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("stalled input transfer changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transfer changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_empty |-> rsp_data.out_byte == 8'h00)
      else $error("end-only result carries a byte");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_empty |-> rsp_data.out_last)
      else $error("end-only result without last");

endmodule

bind base64_stream_codec b64_checker u_b64_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_data    (req_data),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_data    (rsp_data)
);
`default_nettype wire
